@@ src/sha_pkg.sv @@
`default_nettype none
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } sha_state_t;

  typedef struct packed {
    logic       clear_all;
    logic       put_byte;
    logic       pad_start;
    logic       len_fill;
    logic       zero_block;
    logic       load;
    logic       round;
    logic       fold;
    logic       out_step;
  } sha_cmd_t;

  typedef struct packed {
    logic       block_full;
    logic       pad_two;
    logic       round_done;
    logic       out_last;
  } sha_status_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] ror(input logic [31:0] v, input int k);
    ror = (v >> k) | (v << (32 - k));
  endfunction

endpackage
`default_nettype wire

@@ src/sha_datapath.sv @@
`default_nettype none
module sha_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sha_pkg::sha_cmd_t   cmd,
  input  wire logic [7:0]          data_byte,
  output sha_pkg::sha_status_t     status,
  output logic [31:0]              digest_word,
  output logic [2:0]               word_index
);
  import sha_pkg::*;

  // block buffer as 16 big-endian words, byte 0 in the top lane of word 0
  logic [31:0] blk [16];
  logic [31:0] pad_word [16];
  logic [60:0] count;
  logic [31:0] hv [8];
  logic [31:0] w [16];
  logic [31:0] rv [8];
  logic [5:0]  rnd;
  logic [2:0]  oidx;
  logic        pad_two;

  logic [31:0] wt, t1, t2, s0, s1, w_new;
  logic [5:0]  pos;
  logic [63:0] bits;

  assign pos  = count[5:0];
  assign bits = {count, 3'b000};

  always_comb begin
    s0    = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1    = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    wt    = (rnd < 6'd16) ? w[0] : w_new;
    t1 = rv[7] + (ror(rv[4], 6) ^ ror(rv[4], 11) ^ ror(rv[4], 25)) +
         ((rv[4] & rv[5]) ^ (~rv[4] & rv[6])) + ROUND_K[rnd] + wt;
    t2 = (ror(rv[0], 2) ^ ror(rv[0], 13) ^ ror(rv[0], 22)) +
         ((rv[0] & rv[1]) ^ (rv[0] & rv[2]) ^ (rv[1] & rv[2]));
  end

  // 0x80 at the fill position, zeros after it
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      pad_word[j] = blk[j];
      for (int b = 0; b < 4; b++) begin
        if (6'(4*j + b) == pos) pad_word[j][31-8*b -: 8] = PAD_BYTE;
        else if (6'(4*j + b) > pos) pad_word[j][31-8*b -: 8] = 8'h00;
      end
    end
  end

  // window holds w[t-16..t-1] from round 16 on; the first 16 rounds just rotate loaded words
  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      blk[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= data_byte;
    end
    if (cmd.pad_start) begin
      for (int j = 0; j < 16; j++) blk[j] <= pad_word[j];
    end
    if (cmd.zero_block) begin
      for (int j = 0; j < 16; j++) blk[j] <= 32'h0;
    end
    if (cmd.len_fill) begin
      blk[14] <= bits[63:32];
      blk[15] <= bits[31:0];
    end
    if (cmd.load) begin
      for (int j = 0; j < 16; j++) w[j] <= blk[j];
      for (int j = 0; j < 8; j++) rv[j] <= hv[j];
    end
    if (cmd.round) begin
      for (int j = 0; j < 15; j++) w[j] <= w[j+1];
      w[15] <= wt;
      rv[7] <= rv[6]; rv[6] <= rv[5]; rv[5] <= rv[4]; rv[4] <= rv[3] + t1;
      rv[3] <= rv[2]; rv[2] <= rv[1]; rv[1] <= rv[0]; rv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      for (int j = 0; j < 8; j++) hv[j] <= INIT_HASH[j];
      count   <= '0;
      rnd     <= '0;
      oidx    <= '0;
      pad_two <= 1'b0;
    end else begin
      if (cmd.put_byte) count <= count + 61'd1;
      if (cmd.pad_start) pad_two <= (pos >= 6'd56);
      if (cmd.len_fill || cmd.zero_block) pad_two <= 1'b0;
      if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.fold) begin
        for (int j = 0; j < 8; j++) hv[j] <= hv[j] + rv[j];
      end
      if (cmd.out_step) oidx <= oidx + 3'd1;
    end
  end

  assign status.block_full = (pos == 6'd63);
  assign status.pad_two    = pad_two;
  assign status.round_done = (rnd == 6'd63);
  assign status.out_last   = (oidx == 3'd7);
  assign digest_word = hv[oidx];
  assign word_index  = oidx;
endmodule
`default_nettype wire

@@ src/sha_control.sv @@
`default_nettype none
module sha_control (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                byte_present,
  input  wire logic                last_byte,
  input  wire logic                out_ready,
  input  wire sha_pkg::sha_status_t status,
  output logic                     in_ready,
  output logic                     out_valid,
  output sha_pkg::sha_cmd_t        cmd
);
  import sha_pkg::*;

  sha_state_t state, state_next;
  logic       final_pend, final_pend_next;
  logic       padded, padded_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      final_pend <= 1'b0;
      padded     <= 1'b0;
    end else begin
      state      <= state_next;
      final_pend <= final_pend_next;
      padded     <= padded_next;
    end
  end

  always_comb begin
    state_next      = state;
    final_pend_next = final_pend;
    padded_next     = padded;
    cmd             = '0;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.put_byte = byte_present;
          if (byte_present && status.block_full) begin
            final_pend_next = last_byte;
            state_next      = ST_LOAD;
          end else if (last_byte) begin
            final_pend_next = 1'b1;
            state_next      = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.pad_start = 1'b1;
        padded_next   = 1'b1;
        state_next    = ST_LEN;
      end
      ST_LEN: begin
        // no room for the length when the pad marker sits past byte 55
        if (!status.pad_two) cmd.len_fill = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (status.round_done) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!final_pend) begin
          state_next = ST_IDLE;
        end else if (!padded) begin
          state_next = ST_PAD;
        end else if (status.pad_two) begin
          cmd.zero_block = 1'b1;
          state_next     = ST_LEN;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_step = 1'b1;
          if (status.out_last) begin
            cmd.clear_all   = 1'b1;
            final_pend_next = 1'b0;
            padded_next     = 1'b0;
            state_next      = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ src/sha256_stream_hasher.sv @@
`default_nettype none
// SHA-256 over a byte stream. One byte is taken per cycle while a block
// fills; each full 64-byte block then passes through load, 64 rounds of
// the single round unit and fold, during which input is held off. A last
// item adds padding setup (and a second length step when the padding spills
// into a second block) plus one or two compressions, after which the eight
// digest words leave most significant first, one per accepted output cycle,
// and the hasher returns to its initial state.
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // byte_present
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, zero pad
  output logic             m_tlast    // last_word
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  sha_status_t status;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  sha_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .byte_present(s_tuser),
    .last_byte(s_tlast), .out_ready(m_tready), .status(status),
    .in_ready(s_tready), .out_valid(m_tvalid), .cmd(cmd)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_byte(s_tdata), .status(status),
    .digest_word(digest_word), .word_index(word_index)
  );

  assign m_tdata = {5'b0, word_index, digest_word};
  assign m_tlast = (word_index == 3'd7);
endmodule
`default_nettype wire

@@ src/sha_checker.sv @@
`default_nettype none
module sha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tlast
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready)) else $error("input open during digest");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7))) else $error("tlast mismatch");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid &&
      m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)) else $error("index skip");
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (m_tdata[34:32] == 3'd0)) else $error("bad first word");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("unstable");
endmodule

bind sha256_stream_hasher sha_checker u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
